[sv/vcc_pkg.sv]
// ----------------------------------------------------------------------------
// vcc_pkg
// Shared types and constants of the voice capture conditioner: item structs,
// register indexes, filter and knee constants and the sequencer states.
// ----------------------------------------------------------------------------
package vcc_pkg;

	// default decimation factor (legal range 2 to 8)
	localparam int DECIMATION_DEF = 3;

	// dc blocker coefficient, about 0.995 in Q16
	localparam int HP_COEF_Q16 = 65208;

	// soft knee start and hard limit, output units
	localparam int KNEE  = 22000;
	localparam int LIMIT = 31000;

	// configuration port
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_Q8        = 2'd0,
		REG_WARMUP_FRAMES  = 2'd1,
		REG_TARGET_SAMPLES = 2'd2
	} vcc_reg_t;

	// register reset values
	localparam logic [15:0] GAIN_RST   = 16'd2048;
	localparam logic [19:0] WARMUP_RST = 20'd12000;
	localparam logic [19:0] TARGET_RST = 20'd80000;

	// one stereo input frame
	typedef struct packed {
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
	} vcc_in_t;

	// one conditioned output sample
	typedef struct packed {
		logic signed [15:0] out_sample;
		logic [15:0]        in_peak_mag;
		logic [15:0]        out_peak_mag;
		logic               last_sample;
	} vcc_out_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MULF,
		ST_FILT,
		ST_ACC,
		ST_MULG,
		ST_ABS,
		ST_SPLIT,
		ST_DIV,
		ST_OUT
	} vcc_state_t;

endpackage

[sv/voice_capture_conditioner_top.sv]
// ----------------------------------------------------------------------------
// voice_capture_conditioner_top
// Stereo frames in, mono conditioned samples out: louder-channel pick, dc
// blocking high-pass, decimating average, Q8 gain and soft knee limiting.
// ----------------------------------------------------------------------------
//  channel   signals                          dir   payload
//  frame     frame_valid / frame_ready        in    vcc_in_t  (left, right)
//  result    result_valid / result_ready      out   vcc_out_t (sample, peaks, last)
//  config    cfg_we / cfg_index / cfg_data    in    gain, warmup, target registers
//
//  Warmup frames are multiplied and filtered; others are also accumulated, and
//  the last of each group is gained, knee split, divided and output. One shared
//  multiplier does filter feedback, gain and the reciprocal divide by the
//  decimation factor. frame_ready is high only in the idle state. A finished
//  sample sits in the result register; the sequencer waits there only if the
//  previous sample was not yet taken. Reset clears filter, counters, peaks and
//  registers to their defaults. Frames after the target count are dropped.
// ----------------------------------------------------------------------------
module voice_capture_conditioner_top
	import vcc_pkg::*;
#(
	parameter int DECIMATION = DECIMATION_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 frame_valid,
	output logic                 frame_ready,
	input  vcc_in_t              frame,
	output logic                 result_valid,
	input  logic                 result_ready,
	output vcc_out_t             result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// derived widths and constants
	localparam int PH_W    = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
	localparam int NUM_W   = $clog2(KNEE * DECIMATION + 1);
	localparam int PROD_W  = 46;
	localparam int ABS_W   = 44;
	localparam int MULB_W  = 18;
	localparam int CLAMP_N = (LIMIT - KNEE + 1) * DECIMATION;
	localparam longint unsigned KNEE_LIM =
		longint'(KNEE) * longint'(DECIMATION) * 64'd65536;
	localparam logic [ABS_W-1:0] KNEE_LIM_W = ABS_W'(KNEE_LIM);
	localparam int EXC_W   = ABS_W - 18;
	// reciprocal of the decimation factor, exact for every numerator below 2^NUM_W
	localparam int RECIP_SH = NUM_W + PH_W;
	localparam longint RECIP_M =
		((longint'(1) << RECIP_SH) + longint'(DECIMATION) - 1) / longint'(DECIMATION);

	// control registers
	vcc_state_t              state_q, state_d;
	logic [15:0]             gain_q;
	logic [19:0]             warmup_q;
	logic [19:0]             target_q;
	logic signed [15:0]      prev_input_q;
	logic signed [25:0]      prev_filt_q;
	logic signed [27:0]      acc_q;
	logic [PH_W-1:0]         phase_q;
	logic [19:0]             frame_cnt_q;
	logic [19:0]             emitted_q;
	logic [15:0]             in_peak_q;
	logic [15:0]             out_peak_q;
	logic                    out_valid_q;

	// payload registers
	logic signed [15:0]      left_q;
	logic signed [15:0]      right_q;
	logic signed [PROD_W-1:0] product_q;
	logic [ABS_W-1:0]        abs_q;
	logic                    sign_q;
	logic                    upper_q;
	logic [NUM_W-1:0]        div_q;
	vcc_out_t                result_q;

	// combinational signals
	logic                    frame_acc;
	logic                    out_load;
	logic                    done_all;
	logic [15:0]             left_abs;
	logic [15:0]             right_abs;
	logic signed [15:0]      x_sel;
	logic signed [27:0]      mul_a;
	logic [MULB_W-1:0]       mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [PROD_W-1:0] rnd_sum;
	logic signed [16:0]      diff;
	logic signed [30:0]      filt_sum;
	logic signed [25:0]      filt_y;
	logic                    warm;
	logic signed [28:0]      acc_sum;
	logic signed [27:0]      acc_sat;
	logic [15:0]             peak_lr;
	logic [ABS_W-1:0]        prod_abs;
	logic                    over_knee;
	logic [ABS_W-1:0]        excess;
	logic [EXC_W-1:0]        exc_sh;
	logic [NUM_W-1:0]        num;
	logic [15:0]             quo16;
	logic [15:0]             knee_sum;
	logic [15:0]             mag;
	logic [15:0]             new_out_peak;
	logic [19:0]             emitted_inc;

	assign frame_acc    = frame_valid && frame_ready;
	assign out_load     = !out_valid_q || result_ready;
	assign done_all     = emitted_q >= target_q;
	assign result_valid = out_valid_q;
	assign result       = result_q;

	// channel magnitudes and louder-channel pick, ties to left
	assign left_abs  = left_q[15] ? 16'(-left_q) : 16'(left_q);
	assign right_abs = right_q[15] ? 16'(-right_q) : 16'(right_q);
	assign x_sel     = (left_abs >= right_abs) ? left_q : right_q;
	assign peak_lr   = (left_abs > right_abs) ? left_abs : right_abs;

	// shared multiplier: filter feedback, gain or reciprocal of the factor
	always_comb begin
		if (state_q == ST_MULG) begin
			mul_a = acc_q;
			mul_b = MULB_W'(gain_q);
		end else if (state_q == ST_DIV) begin
			mul_a = 28'(RECIP_M);
			mul_b = MULB_W'(div_q);
		end else begin
			mul_a = 28'(prev_filt_q);
			mul_b = MULB_W'(HP_COEF_Q16);
		end
	end
	assign mul_p = PROD_W'(mul_a * $signed({1'b0, mul_b}));

	// high-pass output with rounding and 26-bit saturation
	assign rnd_sum  = product_q + PROD_W'(32768);
	assign diff     = 17'(x_sel) - 17'(prev_input_q);
	assign filt_sum = 31'($signed({diff, 8'b0})) + 31'($signed(rnd_sum[PROD_W-1:16]));
	always_comb begin
		if (filt_sum > 31'sd33554431)
			filt_y = 26'sh1FFFFFF;
		else if (filt_sum < -31'sd33554432)
			filt_y = -26'sd33554432;
		else
			filt_y = 26'(filt_sum);
	end
	assign warm = frame_cnt_q < warmup_q;

	// decimation accumulator with 28-bit saturation
	assign acc_sum = 29'(acc_q) + 29'(prev_filt_q);
	always_comb begin
		if (acc_sum[28] != acc_sum[27])
			acc_sat = acc_sum[28] ? -28'sd134217728 : 28'sh7FFFFFF;
		else
			acc_sat = acc_sum[27:0];
	end

	// magnitude of the gained sum and knee split
	assign prod_abs  = product_q[PROD_W-1] ? ABS_W'(-product_q) : ABS_W'(product_q);
	assign over_knee = abs_q > KNEE_LIM_W;
	assign excess    = abs_q - KNEE_LIM_W;
	assign exc_sh    = excess[ABS_W-1:18];
	always_comb begin
		if (over_knee)
			num = (exc_sh > EXC_W'(CLAMP_N)) ? NUM_W'(CLAMP_N) : NUM_W'(exc_sh);
		else
			num = NUM_W'(abs_q[ABS_W-1:16]);
	end

	// final magnitude, knee limit and peak
	assign quo16        = product_q[RECIP_SH+15:RECIP_SH];
	assign knee_sum     = 16'(KNEE) + quo16;
	assign mag          = upper_q ? ((knee_sum > 16'(LIMIT)) ? 16'(LIMIT) : knee_sum)
	                              : quo16;
	assign new_out_peak = (mag > out_peak_q) ? mag : out_peak_q;
	assign emitted_inc  = emitted_q + 20'd1;

	// next state and handshake
	always_comb begin
		state_d     = state_q;
		frame_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				frame_ready = 1'b1;
				if (frame_valid && !done_all)
					state_d = ST_MULF;
			end
			ST_MULF:  state_d = ST_FILT;
			ST_FILT:  state_d = warm ? ST_IDLE : ST_ACC;
			ST_ACC:   state_d = (phase_q == PH_W'(DECIMATION - 1)) ? ST_MULG : ST_IDLE;
			ST_MULG:  state_d = ST_ABS;
			ST_ABS:   state_d = ST_SPLIT;
			ST_SPLIT: state_d = ST_DIV;
			ST_DIV:   state_d = ST_OUT;
			ST_OUT: begin
				if (out_load)
					state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// control state, filter memory, counters, peaks and config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q       <= GAIN_RST;
			warmup_q     <= WARMUP_RST;
			target_q     <= TARGET_RST;
			prev_input_q <= '0;
			prev_filt_q  <= '0;
			acc_q        <= '0;
			phase_q      <= '0;
			frame_cnt_q  <= '0;
			emitted_q    <= '0;
			in_peak_q    <= '0;
			out_peak_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_GAIN_Q8:        gain_q   <= cfg_data[15:0];
					REG_WARMUP_FRAMES:  warmup_q <= cfg_data;
					REG_TARGET_SAMPLES: target_q <= cfg_data;
					default: ;
				endcase
			end

			// result register handshake
			if (state_q == ST_OUT && out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && result_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_FILT: begin
					prev_input_q <= x_sel;
					prev_filt_q  <= filt_y;
					if (warm) begin
						frame_cnt_q <= frame_cnt_q + 20'd1;
						acc_q       <= '0;
						phase_q     <= '0;
					end
				end
				ST_ACC: begin
					acc_q   <= acc_sat;
					phase_q <= phase_q + PH_W'(1);
					if (peak_lr > in_peak_q)
						in_peak_q <= peak_lr;
				end
				ST_OUT: begin
					if (out_load) begin
						acc_q       <= '0;
						phase_q     <= '0;
						emitted_q   <= emitted_inc;
						out_peak_q  <= new_out_peak;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath payload registers
	always_ff @(posedge clk) begin
		if (frame_acc) begin
			left_q  <= frame.left_sample;
			right_q <= frame.right_sample;
		end
		case (state_q)
			ST_MULF, ST_MULG, ST_DIV: product_q <= mul_p;
			ST_ABS: begin
				abs_q  <= prod_abs;
				sign_q <= product_q[PROD_W-1];
			end
			ST_SPLIT: begin
				div_q   <= num;
				upper_q <= over_knee;
			end
			ST_OUT: begin
				if (out_load) begin
					result_q.out_sample   <= sign_q ? -$signed(mag) : $signed(mag);
					result_q.in_peak_mag  <= in_peak_q;
					result_q.out_peak_mag <= new_out_peak;
					result_q.last_sample  <= emitted_inc == target_q;
				end
			end
			default: ;
		endcase
	end

endmodule

[sim/vcc_checker.sv]
// ----------------------------------------------------------------------------
// vcc_checker
// Watches the frame, result and configuration ports of the voice capture
// conditioner. It keeps its own copy of the registers and the filter and
// decimation state, predicts the sample that each accepted frame produces and
// compares every accepted result field by field, in order.
// ----------------------------------------------------------------------------
module vcc_checker
	import vcc_pkg::*;
#(
	parameter int DECIMATION = DECIMATION_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 frame_valid,
	input  logic                 frame_ready,
	input  vcc_in_t              frame,
	input  logic                 result_valid,
	input  logic                 result_ready,
	input  vcc_out_t             result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   samples_due,
	output int                   samples_emitted
);

	localparam int REPORT_LIMIT = 10;

	// register copies
	logic [15:0] gain;
	logic [19:0] warmup;
	logic [19:0] target;

	// filter and decimation state
	logic signed [15:0] last_pick;
	logic signed [25:0] hp_state;
	logic signed [27:0] avg_sum;
	int                 phase_cnt;
	logic [19:0]        warm_cnt;
	logic [19:0]        emit_cnt;
	logic [15:0]        in_peak;
	logic [15:0]        out_peak;

	vcc_out_t expected_samples[$];
	int       results_seen;

	initial begin
		fail_count      = 0;
		samples_due     = 0;
		samples_emitted = 0;
		results_seen    = 0;
	end

	// state after reset
	task automatic clear_model();
		gain      = GAIN_RST;
		warmup    = WARMUP_RST;
		target    = TARGET_RST;
		last_pick = '0;
		hp_state  = '0;
		avg_sum   = '0;
		phase_cnt = 0;
		warm_cnt  = '0;
		emit_cnt  = '0;
		in_peak   = '0;
		out_peak  = '0;
		expected_samples.delete();
	endtask

	// signed saturation to the given width
	function automatic longint clip(input longint v, input int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) << (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// advance the model by one frame; returns 1 when a sample comes out
	function automatic bit condition_frame(input vcc_in_t f, output vcc_out_t r);
		longint lval;
		longint rval;
		longint la;
		longint ra;
		longint x;
		longint y;
		longint t;
		longint a;
		longint d;
		longint mag;
		longint s;
		r = '0;
		lval = $signed(f.left_sample);
		rval = $signed(f.right_sample);
		la = (lval < 0) ? -lval : lval;
		ra = (rval < 0) ? -rval : rval;

		// target reached: the frame is dropped without any effect
		if (emit_cnt >= target)
			return 1'b0;

		// louder channel, ties to left, then the dc blocker
		x = (la >= ra) ? lval : rval;
		y = clip((x - longint'(last_pick)) * 256
			+ ((longint'(hp_state) * HP_COEF_Q16 + 32768) >>> 16), 26);
		last_pick = x[15:0];
		hp_state  = y[25:0];

		// warmup only moves the filter
		if (warm_cnt < warmup) begin
			warm_cnt  = warm_cnt + 1'b1;
			avg_sum   = '0;
			phase_cnt = 0;
			return 1'b0;
		end

		if (la > longint'(in_peak))
			in_peak = la[15:0];
		if (ra > longint'(in_peak))
			in_peak = ra[15:0];

		avg_sum   = 28'(clip(longint'(avg_sum) + y, 28));
		phase_cnt = phase_cnt + 1;
		if (phase_cnt < DECIMATION)
			return 1'b0;

		// gained average with soft knee and hard limit
		t = longint'(avg_sum) * longint'(gain);
		a = (t < 0) ? -t : t;
		d = longint'(DECIMATION) * 65536;
		if (a <= KNEE * d) begin
			mag = a / d;
		end else begin
			mag = KNEE + (a - KNEE * d) / (4 * d);
			if (mag > LIMIT)
				mag = LIMIT;
		end
		s = (t < 0) ? -mag : mag;

		avg_sum   = '0;
		phase_cnt = 0;
		emit_cnt  = emit_cnt + 1'b1;
		if (mag > longint'(out_peak))
			out_peak = mag[15:0];

		r.out_sample   = s[15:0];
		r.in_peak_mag  = in_peak;
		r.out_peak_mag = out_peak;
		r.last_sample  = (emit_cnt == target);
		return 1'b1;
	endfunction

	// compare one accepted result with the oldest prediction
	task automatic check_result(input vcc_out_t got);
		vcc_out_t want;
		results_seen = results_seen + 1;
		if (expected_samples.size() == 0) begin
			fail_count = fail_count + 1;
			if (fail_count <= REPORT_LIMIT)
				$display("result %0d arrived with none expected: sample %0d in_peak %0d",
					results_seen, got.out_sample, got.in_peak_mag);
			return;
		end
		want = expected_samples.pop_front();
		if (got.out_sample !== want.out_sample || got.in_peak_mag !== want.in_peak_mag
			|| got.out_peak_mag !== want.out_peak_mag
			|| got.last_sample !== want.last_sample) begin
			fail_count = fail_count + 1;
			if (fail_count <= REPORT_LIMIT) begin
				$display("result %0d expected: sample %0d in_peak %0d out_peak %0d last %0d",
					results_seen, want.out_sample, want.in_peak_mag, want.out_peak_mag,
					want.last_sample);
				$display("result %0d got:      sample %0d in_peak %0d out_peak %0d last %0d",
					results_seen, got.out_sample, got.in_peak_mag, got.out_peak_mag,
					got.last_sample);
			end
		end
	endtask

	initial clear_model();

	// port monitor
	always @(posedge clk) begin
		vcc_out_t predicted;
		if (!arst_n) begin
			clear_model();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GAIN_Q8:        gain   = cfg_data[15:0];
					REG_WARMUP_FRAMES:  warmup = cfg_data[19:0];
					REG_TARGET_SAMPLES: target = cfg_data[19:0];
					default:            ;
				endcase
			end
			if (frame_valid && frame_ready) begin
				if (condition_frame(frame, predicted))
					expected_samples.push_back(predicted);
			end
			if (result_valid && result_ready)
				check_result(result);
		end
		samples_due     <= expected_samples.size();
		samples_emitted <= int'(emit_cnt);
	end

endmodule

[sim/voice_capture_conditioner_top_tb.sv]
// ----------------------------------------------------------------------------
// voice_capture_conditioner_top_tb
// Drives stereo frames and register writes into the voice capture conditioner
// while a checker beside it predicts every sample. A directed part covers the
// channel pick on ties, warmup cut short, gain extremes, knee and limit, the
// unused register index and the end of emission; random phases follow with
// varied gain, warmup and idling on both channels, including a long receiver
// hold-off.
// ----------------------------------------------------------------------------
module voice_capture_conditioner_top_tb;
	import vcc_pkg::*;

	localparam int                   WATCHDOG_LIMIT = 5000;
	localparam int                   SETTLE_CYCLES  = 40;
	localparam int                   HOLD_CYCLES    = 300;
	localparam int                   PHASE_ITEMS    = 200;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE      = 2'd3;
	localparam logic [CFG_W-1:0]     GAIN_UNITY     = 20'd256;
	localparam logic [CFG_W-1:0]     GAIN_MAX       = 20'd32768;
	localparam logic [CFG_W-1:0]     WARMUP_MAX     = 20'hFFFFF;
	localparam logic [CFG_W-1:0]     TARGET_MAX     = 20'hFFFFF;

	logic                 clk;
	logic                 arst_n;
	logic                 frame_valid;
	logic                 frame_ready;
	vcc_in_t              frame;
	logic                 result_valid;
	logic                 result_ready;
	vcc_out_t             result;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	int   fail_count;
	int   samples_due;
	int   samples_emitted;
	int   idle_pct;
	int   stall_pct;
	logic hold_req;
	int   hold_left;
	int   quiet_cycles;
	int   dc_offset;

	voice_capture_conditioner_top #(
		.DECIMATION(DECIMATION_DEF)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.frame        (frame),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	vcc_checker #(
		.DECIMATION(DECIMATION_DEF)
	) i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.frame_valid     (frame_valid),
		.frame_ready     (frame_ready),
		.frame           (frame),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.result          (result),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.samples_due     (samples_due),
		.samples_emitted (samples_emitted)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// result receiver: random stalls, or a counted hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req <= 1'b0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if ((frame_valid && frame_ready) || (result_valid && result_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic vcc_in_t frame_of(input int lval, input int rval);
		vcc_in_t f;
		f.left_sample  = 16'(lval);
		f.right_sample = 16'(rval);
		return f;
	endfunction

	function automatic logic [15:0] extreme_value();
		case ($urandom_range(4))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2:       return 16'h0000;
			3:       return 16'hFFFF;
			default: return 16'h0001;
		endcase
	endfunction

	// random frame: full range, quiet signal on a drifting offset, extremes, ties
	function automatic vcc_in_t rand_frame();
		vcc_in_t     f;
		int          pick;
		logic [15:0] v;
		pick = $urandom_range(99);
		if (pick < 40) begin
			f = vcc_in_t'($urandom);
		end else if (pick < 65) begin
			if ($urandom_range(49) == 0)
				dc_offset = int'($urandom_range(40000)) - 20000;
			f.left_sample  = 16'(dc_offset + int'($urandom_range(600)) - 300);
			f.right_sample = 16'(dc_offset + int'($urandom_range(600)) - 300);
		end else if (pick < 85) begin
			f.left_sample  = extreme_value();
			f.right_sample = extreme_value();
		end else begin
			v = 16'($urandom);
			f.left_sample  = v;
			f.right_sample = $urandom_range(1) ? -v : v;
		end
		return f;
	endfunction

	// one frame, after random idle cycles; valid stays up until accepted
	task automatic send_frame(input vcc_in_t f);
		while ($urandom_range(99) < idle_pct) begin
			frame_valid <= 1'b0;
			@(posedge clk);
		end
		frame       <= f;
		frame_valid <= 1'b1;
		do
			@(posedge clk);
		while (!frame_ready);
	endtask

	// stop sending and wait for every predicted sample
	task automatic drain_results();
		frame_valid <= 1'b0;
		do
			@(posedge clk);
		while (samples_due != 0);
	endtask

	// drained and past the longest frame latency: safe for register writes
	task automatic settle_block();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// stimulus and verdict
	initial begin
		logic [CFG_W-1:0] phase_gain;
		int               items;
		arst_n       = 1'b0;
		frame_valid  = 1'b0;
		frame        = '0;
		result_ready = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_GAIN_Q8;
		cfg_data     = '0;
		idle_pct     = 0;
		stall_pct    = 0;
		hold_req     = 1'b0;
		hold_left    = 0;
		quiet_cycles = 0;
		dc_offset    = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// longest warmup, then cut short below the frame count
		write_reg(REG_GAIN_Q8, GAIN_UNITY);
		write_reg(REG_WARMUP_FRAMES, WARMUP_MAX);
		write_reg(REG_TARGET_SAMPLES, TARGET_MAX);
		send_frame(frame_of(1000, -200));
		send_frame(frame_of(-32768, 5));
		send_frame(frame_of(7, 7));
		settle_block();
		write_reg(REG_WARMUP_FRAMES, 20'd1);

		// channel pick on ties and full scale inputs
		send_frame(frame_of(32767, -32768));
		send_frame(frame_of(-32768, -32768));
		send_frame(frame_of(5, -5));
		send_frame(frame_of(0, 0));
		send_frame(frame_of(-32768, 32767));
		send_frame(frame_of(32767, 32767));

		// a high gain drives the knee and the limit
		settle_block();
		write_reg(REG_GAIN_Q8, GAIN_MAX);
		send_frame(frame_of(32767, 0));
		send_frame(frame_of(-32768, 0));
		send_frame(frame_of(32767, -1));
		send_frame(frame_of(-32768, 1));
		send_frame(frame_of(32767, 0));
		send_frame(frame_of(32767, 0));

		// zero gain gives silence
		settle_block();
		write_reg(REG_GAIN_Q8, 20'd0);
		send_frame(frame_of(-32768, 0));
		send_frame(frame_of(32767, 0));
		send_frame(frame_of(123, -456));

		// all data bits set: gain keeps only its low bits
		settle_block();
		write_reg(REG_GAIN_Q8, 20'hFFFFF);
		send_frame(frame_of(-32768, 100));
		send_frame(frame_of(32767, -100));
		send_frame(frame_of(-20000, 20000));

		// unused index must leave the gain alone; then hit the target
		settle_block();
		write_reg(REG_SPARE, 20'd1);
		write_reg(REG_TARGET_SAMPLES, CFG_W'(samples_emitted + 1));
		send_frame(frame_of(-32768, 0));
		send_frame(frame_of(32767, 0));
		send_frame(frame_of(-32768, 0));
		send_frame(frame_of(1, 2));
		send_frame(frame_of(-3, 4));

		// target lowered below the count: nothing more comes out
		settle_block();
		write_reg(REG_TARGET_SAMPLES, 20'd0);
		send_frame(frame_of(32767, -32768));

		// random phases
		for (int p = 0; p < 7; p++) begin
			settle_block();
			case (p % 4)
				0: begin
					idle_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					idle_pct = 82;
					stall_pct <= 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct <= 82;
				end
				default: begin
					idle_pct = 12;
					stall_pct <= 12;
				end
			endcase
			case (p)
				0:       phase_gain = GAIN_UNITY;
				1:       phase_gain = GAIN_MAX;
				3:       phase_gain = 20'd1;
				4:       phase_gain = CFG_W'($urandom_range(4096, 512));
				default: phase_gain = CFG_W'($urandom_range(32768, 1));
			endcase
			write_reg(REG_GAIN_Q8, phase_gain);
			write_reg(REG_WARMUP_FRAMES, (p == 0) ? 20'd0 : CFG_W'($urandom_range(20)));
			if (p == 5) begin
				// short phase that runs past the end of emission
				write_reg(REG_TARGET_SAMPLES, CFG_W'(samples_emitted + 10));
				items = 40;
			end else begin
				write_reg(REG_TARGET_SAMPLES, TARGET_MAX);
				items = PHASE_ITEMS;
			end
			if (p == 2)
				hold_req <= 1'b1;
			for (int i = 0; i < items; i++) begin
				if (p == 4 && i == items / 2)
					drain_results();
				send_frame(rand_frame());
			end
		end

		settle_block();
		if (fail_count == 0 && samples_due == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[sim.f]
sv/vcc_pkg.sv
sv/voice_capture_conditioner_top.sv
sim/vcc_checker.sv
sim/voice_capture_conditioner_top_tb.sv
